### design/ansi_escape_text_filter_assert.svh
// Assertion macros shared by the ANSI escape text filter modules.
// Each macro expands to one labeled concurrent assertion with async reset disable.
`ifndef ANSI_ESCAPE_TEXT_FILTER_ASSERT_SVH
`define ANSI_ESCAPE_TEXT_FILTER_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge out of reset.
`define AETF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication checked at every rising clock edge out of reset.
`define AETF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

### design/aetf_pkg.sv
// Package for the ANSI escape text filter: character codes, action codes,
// parser state and result types. No dependencies.
package aetf_pkg;

    // Character codes seen by the parser.
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BEL       = 8'h07;
    localparam logic [7:0] CHAR_BS        = 8'h08;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_ESC       = 8'd27;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_LPAREN    = 8'h28;
    localparam logic [7:0] CHAR_RPAREN    = 8'h29;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_SEMI      = 8'h3B;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_SGR_END   = 8'h6D;
    localparam logic [7:0] CHAR_TILDE     = 8'h7E;
    localparam logic [7:0] CHAR_DEL       = 8'd127;
    localparam logic [7:0] CHAR_CSI       = 8'h9B;
    localparam logic [7:0] CHAR_OSC       = 8'h9D;
    localparam logic [7:0] CHAR_NBSP      = 8'hA0;
    localparam logic [7:0] CHAR_SHY       = 8'hAD;

    // Numeric parameter of a sequence and its select graphic rendition codes.
    localparam int unsigned NUM_W = 10;
    localparam logic [NUM_W-1:0] SECOND_MAX  = 10'd999;
    localparam logic [NUM_W-1:0] SGR_RESET   = 10'd0;
    localparam logic [NUM_W-1:0] SGR_BOLD    = 10'd1;
    localparam logic [NUM_W-1:0] SGR_BLACK   = 10'd30;
    localparam logic [NUM_W-1:0] SGR_RED     = 10'd31;
    localparam logic [NUM_W-1:0] SGR_CYAN    = 10'd36;
    localparam logic [NUM_W-1:0] SGR_WHITE   = 10'd37;
    localparam logic [NUM_W-1:0] SGR_DEFAULT = 10'd39;

    localparam logic [2:0] COLOUR_BLACK = 3'd0;

    // Action codes of one result.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_EMIT   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_STYLE  = 2'd3
    } action_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic             in_sequence;
        logic             in_csi;
        logic             in_osc;
        logic             after_separator;
        logic             second_present;
        logic [NUM_W-1:0] second_number;
    } seq_state_t;

    // One result item.
    typedef struct packed {
        action_t    action;
        logic [7:0] char_out;
        logic       set_colour;
        logic [2:0] colour;
        logic       set_weight;
        logic       bold;
    } result_t;

    // Printable Latin-1: ASCII space to tilde, and no-break space upward except soft hyphen.
    function automatic logic is_printable(input logic [7:0] c);
        return ((c >= CHAR_SPACE) && (c <= CHAR_TILDE))
            || ((c >= CHAR_NBSP) && (c != CHAR_SHY));
    endfunction

endpackage

### design/ansi_escape_text_filter.sv
// ANSI escape text filter: one Latin-1 byte in, one action out per transfer.
// Path: a character moves from the input register into the result register when the
// result register can take it, and leaves the result register at an unstalled transfer.
// Throughput: one transfer per cycle on both channels; the input stalls only while both
// registers hold a character and the result is stalled. Reset (rst_n low, asynchronous)
// empties both registers and clears the escape parser state.
module ansi_escape_text_filter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] action,
    output logic [7:0] char_out,
    output logic       set_colour,
    output logic [2:0] colour,
    output logic       set_weight,
    output logic       bold
);
    import aetf_pkg::*;

    `include "ansi_escape_text_filter_assert.svh"

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result;
    logic       out_ready;
    logic       step;
    logic       in_take;

    // Handshake: each stage moves when the stage after it can take its item.
    assign out_ready = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    aetf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (in_char_reg),
        .result  (result)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= char_in;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = out_result_reg.action;
    assign char_out   = out_result_reg.char_out;
    assign set_colour = out_result_reg.set_colour;
    assign colour     = out_result_reg.colour;
    assign set_weight = out_result_reg.set_weight;
    assign bold       = out_result_reg.bold;

    // The input side stalls only while a character waits behind a stalled result.
    `AETF_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall)
    // A character held in the input register is not lost while stalled.
    `AETF_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !step, in_valid_reg && $stable(in_char_reg))
    // A processed character always lands in the result register.
    `AETF_ASSERT_NEXT(a_step_lands, clk, rst_n, step, out_valid_reg)

endmodule

### design/aetf_style.sv
// Style decoder of the ANSI escape text filter: maps the second number of an
// SGR sequence to a colour or weight change. Depends on aetf_pkg.
module aetf_style (
    input  logic                          second_present,
    input  logic [aetf_pkg::NUM_W-1:0]    second_number,
    output aetf_pkg::result_t             style
);
    import aetf_pkg::*;

    logic [2:0] colour_index;

    assign colour_index = 3'(second_number - SGR_BLACK);

    // Decode the SGR parameter; unsupported values give no action.
    always_comb
    begin
        style = '0;
        if (!second_present || (second_number == SGR_BLACK)
            || (second_number == SGR_WHITE) || (second_number == SGR_DEFAULT))
        begin
            style.action     = ACT_STYLE;
            style.set_colour = 1'b1;
            style.colour     = COLOUR_BLACK;
        end
        else if (second_number == SGR_RESET)
        begin
            style.action     = ACT_STYLE;
            style.set_colour = 1'b1;
            style.colour     = COLOUR_BLACK;
            style.set_weight = 1'b1;
            style.bold       = 1'b0;
        end
        else if (second_number == SGR_BOLD)
        begin
            style.action     = ACT_STYLE;
            style.set_weight = 1'b1;
            style.bold       = 1'b1;
        end
        else if ((second_number >= SGR_RED) && (second_number <= SGR_CYAN))
        begin
            style.action     = ACT_STYLE;
            style.set_colour = 1'b1;
            style.colour     = colour_index;
        end
    end

endmodule

### design/aetf_parser.sv
// Sequence parser of the ANSI escape text filter: holds the escape state and
// works out the result of one character. Depends on aetf_pkg and aetf_style.
module aetf_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_in,
    output aetf_pkg::result_t result
);
    import aetf_pkg::*;

    `include "ansi_escape_text_filter_assert.svh"

    seq_state_t       state_reg;
    seq_state_t       state_next;
    result_t          style;
    logic             is_digit;
    logic [3:0]       digit_value;
    logic [13:0]      scaled;
    logic [NUM_W-1:0] saturated;
    logic             done;

    aetf_style u_style (
        .second_present (state_reg.second_present),
        .second_number  (state_reg.second_number),
        .style          (style)
    );

    // Digit accumulation with saturation of the second number.
    assign is_digit    = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign digit_value = 4'(char_in - CHAR_ZERO);
    assign scaled      = ({4'b0, state_reg.second_number} << 3)
                       + ({4'b0, state_reg.second_number} << 1)
                       + {10'b0, digit_value};
    assign saturated   = (scaled > {4'b0, SECOND_MAX}) ? SECOND_MAX : scaled[NUM_W-1:0];

    // Next state and result for the current character.
    always_comb
    begin
        state_next = state_reg;
        result     = '0;
        done       = 1'b0;
        if (state_reg.in_sequence)
        begin
            if (state_reg.in_csi || state_reg.in_osc)
            begin
                if (is_digit)
                begin
                    if (state_reg.after_separator)
                    begin
                        state_next.second_present = 1'b1;
                        state_next.second_number  = state_reg.second_present
                                                  ? saturated
                                                  : {6'b0, digit_value};
                    end
                end
                else if (char_in == CHAR_SEMI)
                begin
                    state_next.after_separator = 1'b1;
                end
                else if (state_reg.in_osc && (char_in == CHAR_BEL))
                begin
                    done = 1'b1;
                end
                else if (state_reg.in_csi && (char_in != CHAR_NUL))
                begin
                    done = 1'b1;
                end
            end
            else if (char_in == CHAR_LBRACKET)
            begin
                state_next.in_csi = 1'b1;
            end
            else if (char_in == CHAR_RBRACKET)
            begin
                state_next.in_osc = 1'b1;
            end
            else if ((char_in == CHAR_LPAREN) || (char_in == CHAR_RPAREN)
                     || (char_in == CHAR_NUL))
            begin
                state_next = state_reg;
            end
            else
            begin
                done = 1'b1;
            end

            if (done)
            begin
                if (char_in == CHAR_SGR_END)
                begin
                    result = style;
                end
                state_next = '0;
            end
        end
        else if ((char_in == CHAR_CR) || (char_in == CHAR_LF))
        begin
            result.action   = ACT_EMIT;
            result.char_out = CHAR_LF;
        end
        else if (is_printable(char_in))
        begin
            result.action   = ACT_EMIT;
            result.char_out = char_in;
        end
        else if ((char_in == CHAR_DEL) || (char_in == CHAR_BS))
        begin
            result.action = ACT_DELETE;
        end
        else if (char_in == CHAR_ESC)
        begin
            state_next.in_sequence = 1'b1;
        end
        else if (char_in == CHAR_CSI)
        begin
            state_next.in_sequence = 1'b1;
            state_next.in_csi      = 1'b1;
        end
        else if (char_in == CHAR_OSC)
        begin
            state_next.in_sequence = 1'b1;
            state_next.in_osc      = 1'b1;
        end
    end

    // State register, advanced once per processed character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    // A CSI or OSC flag is only ever set inside an open sequence.
    `AETF_ASSERT_NOW(a_kind_in_seq, clk, rst_n, state_reg.in_csi || state_reg.in_osc, state_reg.in_sequence)
    // The second number saturates and is zero until its first digit.
    `AETF_ASSERT_NOW(a_num_range, clk, rst_n, !state_reg.second_present || state_reg.second_number > SECOND_MAX, !state_reg.second_present && state_reg.second_number == '0)
    // Without a processed character the parser state holds.
    `AETF_ASSERT_NEXT(a_state_hold, clk, rst_n, !step, $stable(state_reg))

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ansi_escape_text_filter: directed and random byte streams.
// Expected actions come from a scoreboard class that models the escape parser.
// Depends on aetf_pkg and the ansi_escape_text_filter RTL.
module tb;
    import aetf_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEM_TARGET  = 1500;

    // Predicts one action per input byte and checks results in order.
    class action_scoreboard;
        seq_state_t parse_st;
        result_t    expected_actions [$];
        int         errors;
        int         checked;

        function new();
            parse_st = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        // Advances the parser state by one byte and returns the action it causes.
        function result_t predict_action(input logic [7:0] c);
            result_t          r;
            logic             closes;
            int unsigned      acc;
            logic [NUM_W-1:0] n;
            r      = '0;
            closes = 1'b0;
            if (parse_st.in_sequence)
            begin
                if (parse_st.in_csi || parse_st.in_osc)
                begin
                    // Digits after a separator build the second number.
                    if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    begin
                        if (parse_st.after_separator)
                        begin
                            if (!parse_st.second_present)
                            begin
                                parse_st.second_number  = NUM_W'(c - CHAR_ZERO);
                                parse_st.second_present = 1'b1;
                            end
                            else
                            begin
                                acc = parse_st.second_number * 10 + (c - CHAR_ZERO);
                                parse_st.second_number = (acc > SECOND_MAX) ? SECOND_MAX
                                                                            : NUM_W'(acc);
                            end
                        end
                    end
                    else if (c == CHAR_SEMI)
                        parse_st.after_separator = 1'b1;
                    else if (parse_st.in_osc && c == CHAR_BEL)
                        closes = 1'b1;
                    else if (parse_st.in_csi && c != CHAR_NUL)
                        closes = 1'b1;
                end
                else if (c == CHAR_LBRACKET)
                    parse_st.in_csi = 1'b1;
                else if (c == CHAR_RBRACKET)
                    parse_st.in_osc = 1'b1;
                else if (c == CHAR_LPAREN || c == CHAR_RPAREN || c == CHAR_NUL)
                    closes = 1'b0;
                else
                    closes = 1'b1;

                // A closing 'm' selects a style from the second number.
                if (closes)
                begin
                    if (c == CHAR_SGR_END)
                    begin
                        n = parse_st.second_number;
                        if (!parse_st.second_present || n == SGR_BLACK || n == SGR_WHITE
                            || n == SGR_DEFAULT)
                        begin
                            r.action     = ACT_STYLE;
                            r.set_colour = 1'b1;
                            r.colour     = COLOUR_BLACK;
                        end
                        else if (n == SGR_RESET)
                        begin
                            r.action     = ACT_STYLE;
                            r.set_colour = 1'b1;
                            r.colour     = COLOUR_BLACK;
                            r.set_weight = 1'b1;
                            r.bold       = 1'b0;
                        end
                        else if (n == SGR_BOLD)
                        begin
                            r.action     = ACT_STYLE;
                            r.set_weight = 1'b1;
                            r.bold       = 1'b1;
                        end
                        else if (n >= SGR_RED && n <= SGR_CYAN)
                        begin
                            r.action     = ACT_STYLE;
                            r.set_colour = 1'b1;
                            r.colour     = 3'(n - SGR_BLACK);
                        end
                    end
                    parse_st = '0;
                end
            end
            else if (c == CHAR_CR || c == CHAR_LF)
            begin
                r.action   = ACT_EMIT;
                r.char_out = CHAR_LF;
            end
            else if ((c >= CHAR_SPACE && c <= CHAR_TILDE) || (c >= CHAR_NBSP && c != CHAR_SHY))
            begin
                r.action   = ACT_EMIT;
                r.char_out = c;
            end
            else if (c == CHAR_DEL || c == CHAR_BS)
                r.action = ACT_DELETE;
            else if (c == CHAR_ESC)
                parse_st.in_sequence = 1'b1;
            else if (c == CHAR_CSI)
            begin
                parse_st.in_sequence = 1'b1;
                parse_st.in_csi      = 1'b1;
            end
            else if (c == CHAR_OSC)
            begin
                parse_st.in_sequence = 1'b1;
                parse_st.in_osc      = 1'b1;
            end
            return r;
        endfunction

        function void note_char(input logic [7:0] c);
            expected_actions.push_back(predict_action(c));
        endfunction

        task report(input string what, input int got, input int want);
            $display("mismatch on result %0d: %s is %0d, expected %0d", checked, what, got, want);
            errors++;
        endtask

        // Compares one accepted result with the oldest expectation, field by field.
        task check_action(input result_t got);
            result_t want;
            if (expected_actions.size() == 0)
            begin
                report("action of a result with nothing pending", int'(got.action), -1);
            end
            else
            begin
                want = expected_actions.pop_front();
                if (got.action != want.action)
                    report("action", int'(got.action), int'(want.action));
                if (got.char_out != want.char_out)
                    report("char_out", got.char_out, want.char_out);
                if (got.set_colour != want.set_colour)
                    report("set_colour", got.set_colour, want.set_colour);
                if (got.colour != want.colour)
                    report("colour", got.colour, want.colour);
                if (got.set_weight != want.set_weight)
                    report("set_weight", got.set_weight, want.set_weight);
                if (got.bold != want.bold)
                    report("bold", got.bold, want.bold);
            end
            checked++;
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] action;
    logic [7:0] char_out;
    logic       set_colour;
    logic [2:0] colour;
    logic       set_weight;
    logic       bold;

    action_scoreboard sb;
    int tx_idle_pct = 33;
    int rx_busy_pct = 33;
    int sent        = 0;
    int cycles      = 0;

    ansi_escape_text_filter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .char_out   (char_out),
        .set_colour (set_colour),
        .colour     (colour),
        .set_weight (set_weight),
        .bold       (bold)
    );

    // Free-running clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run ends with a failure if it takes far longer than any correct run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls at random, driven on the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_busy_pct);
    end

    // Every result transfer is checked at the rising edge.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.action     = action_t'(action);
            got.char_out   = char_out;
            got.set_colour = set_colour;
            got.colour     = colour;
            got.set_weight = set_weight;
            got.bold       = bold;
            sb.check_action(got);
        end
    end

    // Offers one byte after a random gap and holds it until the transfer.
    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_char(c);
        sent++;
    endtask

    // Sends a number as decimal digits.
    task automatic send_digits(input int unsigned n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Holds the input idle until every predicted action has come out.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_actions.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] opening_chars [$];
        logic [7:0] b;
        int         pick;
        int         next_pause;

        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_in   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed bytes: field extremes, each action, skipped escape bytes,
        // a digit ending a plain escape, a colour change and a closed OSC.
        opening_chars = '{CHAR_NUL, CHAR_CR, CHAR_LF, CHAR_SPACE, CHAR_TILDE, CHAR_DEL,
                          CHAR_BS, 8'h80, CHAR_NBSP, CHAR_SHY, 8'hFF,
                          CHAR_ESC, CHAR_LPAREN, CHAR_NUL, CHAR_RPAREN, CHAR_ZERO + 8'd5,
                          CHAR_CSI, CHAR_SEMI, CHAR_ZERO + 8'd3, CHAR_ZERO + 8'd1,
                          CHAR_SGR_END, CHAR_OSC, CHAR_SEMI, CHAR_ZERO + 8'd7, CHAR_BEL};
        foreach (opening_chars[i])
            send_char(opening_chars[i]);
        pause_until_drained();

        // Random stream, mostly well-formed sequences with random content.
        next_pause = 300;
        while (sent < ITEM_TARGET)
        begin
            tx_idle_pct = (sent >= 600 && sent < 900) ? 0 : 33;
            rx_busy_pct = tx_idle_pct;
            pick = $urandom_range(19);
            if (pick < 8)
            begin
                // Control sequence, usually closed by 'm'.
                if ($urandom_range(1))
                    send_char(CHAR_CSI);
                else
                begin
                    send_char(CHAR_ESC);
                    if ($urandom_range(3) == 0)
                        send_char(CHAR_LPAREN);
                    send_char(CHAR_LBRACKET);
                end
                if ($urandom_range(1))
                    send_digits($urandom_range(99));
                if ($urandom_range(7) == 0)
                    send_char(CHAR_NUL);
                pick = $urandom_range(9);
                if (pick != 9)
                    send_char(CHAR_SEMI);
                case (pick)
                    0:       send_digits(0);
                    1:       send_digits(1);
                    2, 3, 4: send_digits($urandom_range(30, 39));
                    5:       send_digits($urandom_range(2, 99));
                    6:       send_digits($urandom_range(100, 999));
                    7:       send_digits($urandom_range(1000, 999999));
                    default: ;
                endcase
                if ($urandom_range(9) == 0)
                begin
                    send_char(CHAR_SEMI);
                    send_digits($urandom_range(40));
                end
                if ($urandom_range(4) != 0)
                    send_char(CHAR_SGR_END);
                else
                    send_char(8'($urandom_range(255)));
            end
            else if (pick < 11)
            begin
                // Operating system command with noise, closed by BEL.
                if ($urandom_range(1))
                    send_char(CHAR_OSC);
                else
                begin
                    send_char(CHAR_ESC);
                    send_char(CHAR_RBRACKET);
                end
                repeat ($urandom_range(6))
                begin
                    b = 8'($urandom_range(255));
                    if (b == CHAR_BEL)
                        b = CHAR_SEMI;
                    send_char(b);
                end
                if ($urandom_range(1))
                begin
                    send_char(CHAR_SEMI);
                    send_digits($urandom_range(2000));
                end
                send_char(CHAR_BEL);
            end
            else if (pick < 13)
            begin
                // Plain escape with skipped bytes and a random byte that usually closes it.
                send_char(CHAR_ESC);
                repeat ($urandom_range(2))
                begin
                    case ($urandom_range(2))
                        0:       send_char(CHAR_LPAREN);
                        1:       send_char(CHAR_RPAREN);
                        default: send_char(CHAR_NUL);
                    endcase
                end
                send_char(8'($urandom_range(255)));
            end
            else
            begin
                // Text, half of it any byte value at all.
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(1))
                        send_char(8'($urandom_range(255)));
                    else
                        send_char(8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
                end
            end
            if (sent >= next_pause)
            begin
                pause_until_drained();
                next_pause += 300;
            end
        end

        // Wait for the last results, then a little longer for stray ones.
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
